// File: design/sf6ss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sf6ss_pkg;

  // field widths
  localparam int TEMP_W = 15;
  localparam int SAL_W  = 14;
  localparam int LAT_W  = 16;
  localparam int CONC_W = 24;
  localparam int SOL_W  = 40;

  // internal widths
  localparam int X_W    = 30;   // x in q28, within [2,4)
  localparam int INV_W  = 27;   // 1/x in q28
  localparam int FRAC_W = 28;   // log2 fraction bits
  localparam int W_W    = 40;   // exponent in q28, signed
  localparam int SER_W  = 32;   // series values in q32

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOUTH = 1'b1;

  // stage counts of the sub-units
  localparam int RL_STAGES    = 28;
  localparam int SERIES_TERMS = 14;
  localparam int EXP_LAT      = 3 + 2 * SERIES_TERMS + 2;

  // saturation limit
  localparam logic [SOL_W-1:0] MAX40 = 40'hFF_FFFF_FFFF;

  // x = base + (t * 2^18 + 12) / 25, split as t * 10485 + (t * 19 + 12) / 25
  localparam logic [X_W-1:0] X_BASE      = 30'd561432756;
  localparam logic [13:0]    X_STEP      = 14'd10485;
  localparam logic [4:0]     X_REM_STEP  = 5'd19;
  localparam logic [19:0]    X_ROUND     = 20'd12;
  localparam logic [20:0]    RECIP25     = 21'd1342178;   // ceil(2^25 / 25)
  localparam logic [X_W-1:0] DIV_REM_INIT = 30'd268435456; // 2^56 >> 28

  // weiss coefficients in q28
  localparam logic signed [W_W-1:0] A0_Q28 = -40'sd21484043816;
  localparam logic [34:0] A1_Q28 = 35'd31469225378;
  localparam logic [32:0] A2_Q28 = 33'd7940777129;
  localparam logic signed [31:0] A3_Q28 = 32'sd8997500;
  localparam logic [23:0] A4_MAG_Q28 = 24'd10037929;
  localparam logic [20:0] A5_Q28 = 21'd2080004;

  // logarithm and exponent constants
  localparam logic [FRAC_W:0]   Q28_ONE    = 29'd268435456;
  localparam logic [27:0]       LN2_Q28    = 28'd186065280;
  localparam logic [31:0]       LN2_Q32    = 32'd2977044472;
  localparam logic [28:0]       INVLN2_Q28 = 29'd387270501;
  localparam logic signed [W_W-1:0] W_FLOOR = -40'sd8589934592; // -32 in q28

  // latitude blend
  localparam logic signed [LAT_W-1:0] LAT_BOUND = 16'sd2560;
  localparam logic [12:0] LAT_SPAN  = 13'd5120;
  localparam logic [12:0] LAT_HALF  = 13'd2560;
  localparam logic [27:0] RECIP5    = 28'd214748365;   // ceil(2^30 / 5)

  // reciprocals of 1..14 for exact 32-bit floor division, with their shifts
  localparam logic [32:0] SER_RECIP [SERIES_TERMS] = '{
    33'd4294967296, 33'd4294967296, 33'd5726623062, 33'd4294967296,
    33'd6871947674, 33'd5726623062, 33'd4908534053, 33'd4294967296,
    33'd7635497416, 33'd6871947674, 33'd6247225158, 33'd5726623062,
    33'd5286113596, 33'd4908534053
  };
  localparam int SER_SHIFT [SERIES_TERMS] = '{
    32, 33, 34, 34, 35, 35, 35, 35, 36, 36, 36, 36, 36, 36
  };

endpackage

`default_nettype wire

// File: design/sf6ss_recip_log.sv
`timescale 1ns / 1ps
`default_nettype none

module sf6ss_recip_log
  import sf6ss_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [X_W-1:0]    xq,
  output logic [INV_W-1:0]  inv,
  output logic [FRAC_W-1:0] ln_frac
);

  // one quotient bit and one log2 bit per stage
  logic [X_W-1:0]       rem     [RL_STAGES];
  logic [X_W-1:0]       divisor [RL_STAGES];
  logic [X_W-1:0]       sqr     [RL_STAGES];
  logic [RL_STAGES-1:0] quo     [RL_STAGES];
  logic [FRAC_W-1:0]    frac    [RL_STAGES];

  for (genvar k = 0; k < RL_STAGES; k++) begin : g_stage
    logic [X_W-1:0]       rem_in, div_in, sqr_in;
    logic [RL_STAGES-1:0] quo_in;
    logic [FRAC_W-1:0]    frac_in;
    logic [X_W:0]         rem_dbl;
    logic [2*X_W-1:0]     sq_full;
    logic [X_W:0]         sq_top;
    logic [X_W-1:0]       rem_next, sqr_next;
    logic                 q_bit, f_bit;

    if (k == 0) begin : g_first
      assign rem_in  = DIV_REM_INIT;
      assign div_in  = xq;
      assign sqr_in  = xq;
      assign quo_in  = '0;
      assign frac_in = '0;
    end else begin : g_next
      assign rem_in  = rem[k-1];
      assign div_in  = divisor[k-1];
      assign sqr_in  = sqr[k-1];
      assign quo_in  = quo[k-1];
      assign frac_in = frac[k-1];
    end

    // restoring division step and squaring step
    always_comb begin
      rem_dbl  = {rem_in, 1'b0};
      q_bit    = rem_dbl >= {1'b0, div_in};
      rem_next = q_bit ? X_W'(rem_dbl - {1'b0, div_in}) : rem_dbl[X_W-1:0];
      sq_full  = sqr_in * sqr_in;
      sq_top   = sq_full[2*X_W-1:X_W-1];
      f_bit    = sq_top[X_W];
      sqr_next = f_bit ? sq_top[X_W:1] : sq_top[X_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]     <= rem_next;
        divisor[k] <= div_in;
        sqr[k]     <= sqr_next;
        quo[k]     <= {quo_in[RL_STAGES-2:0], q_bit};
        frac[k]    <= {frac_in[FRAC_W-2:0], f_bit};
      end
    end
  end

  assign inv     = quo[RL_STAGES-1][INV_W-1:0];
  assign ln_frac = frac[RL_STAGES-1];

endmodule

`default_nettype wire

// File: design/sf6ss_exp.sv
`timescale 1ns / 1ps
`default_nettype none

module sf6ss_exp
  import sf6ss_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W_W-1:0] w,
  output logic [SOL_W-1:0]      sol
);

  typedef struct packed {
    logic [SER_W-1:0] t;
    logic [5:0]       n;
    logic             hi;
    logic             lo;
  } exp_side_t;

  // range flags and magnitude
  logic        hi1, lo1;
  logic [33:0] mag1;

  always_ff @(posedge clk) begin
    if (en) begin
      hi1  <= ~w[W_W-1];
      lo1  <= w < W_FLOOR;
      mag1 <= 34'(-w);
    end
  end

  // split w / ln2 into integer and fraction
  logic [62:0] m_full;
  logic [5:0]  n2;
  logic [27:0] f2;
  logic        hi2, lo2;

  assign m_full = mag1 * INVLN2_Q28;

  always_ff @(posedge clk) begin
    if (en) begin
      n2  <= m_full[61:56];
      f2  <= m_full[55:28];
      hi2 <= hi1;
      lo2 <= lo1;
    end
  end

  // fraction times ln2 in q32
  logic [59:0] t_full;
  exp_side_t   side3;

  assign t_full = f2 * LN2_Q32;

  always_ff @(posedge clk) begin
    if (en) begin
      side3.t  <= t_full[59:28];
      side3.n  <= n2;
      side3.hi <= hi2;
      side3.lo <= lo2;
    end
  end

  // alternating series, a multiply stage and a divide stage per term
  logic [SER_W-1:0]   prod_p [SERIES_TERMS];
  logic signed [34:0] sum_p  [SERIES_TERMS];
  exp_side_t          side_p [SERIES_TERMS];
  logic [SER_W:0]     term_d [SERIES_TERMS];
  logic signed [34:0] sum_d  [SERIES_TERMS];
  exp_side_t          side_d [SERIES_TERMS];

  for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_term
    logic [SER_W:0]     term_in;
    logic signed [34:0] sum_in, sum_next;
    exp_side_t          side_in;
    logic [2*SER_W:0]   mul_full;
    logic [65:0]        div_full;
    logic [65:0]        div_shift;

    if (k == 0) begin : g_first
      assign term_in  = 33'd4294967296;
      assign sum_in   = 35'sd4294967296;
      assign side_in  = side3;
      assign sum_next = sum_in;
    end else begin : g_next
      assign term_in = term_d[k-1];
      assign sum_in  = sum_d[k-1];
      assign side_in = side_d[k-1];
      if (k % 2 == 1) begin : g_sub
        assign sum_next = sum_in - $signed({2'b00, term_in});
      end else begin : g_add
        assign sum_next = sum_in + $signed({2'b00, term_in});
      end
    end

    assign mul_full  = term_in * side_in.t;
    assign div_full  = prod_p[k] * SER_RECIP[k];
    assign div_shift = div_full >> SER_SHIFT[k];

    always_ff @(posedge clk) begin
      if (en) begin
        prod_p[k] <= mul_full[2*SER_W-1:SER_W];
        sum_p[k]  <= sum_next;
        side_p[k] <= side_in;
        term_d[k] <= div_shift[SER_W:0];
        sum_d[k]  <= sum_p[k];
        side_d[k] <= side_p[k];
      end
    end
  end

  // last term is of even order, so it adds
  logic signed [34:0] sum_f;
  exp_side_t          side_f;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_f  <= sum_d[SERIES_TERMS-1] + $signed({2'b00, term_d[SERIES_TERMS-1]});
      side_f <= side_d[SERIES_TERMS-1];
    end
  end

  // scale by 2^(8-n) with round half up, then clamp
  logic [32:0]      mant;
  logic [40:0]      shl;
  logic [5:0]       sh;
  logic [33:0]      rnd;
  logic [33:0]      shr;
  logic [SOL_W-1:0] sol_next;

  always_comb begin
    mant = sum_f[34] ? '0 : sum_f[32:0];
    shl  = 41'(mant) << (6'd8 - side_f.n);
    sh   = side_f.n - 6'd8;
    rnd  = {1'b0, mant} + (34'd1 << (sh - 6'd1));
    shr  = rnd >> sh;
    if (side_f.hi) begin
      sol_next = MAX40;
    end else if (side_f.lo) begin
      sol_next = '0;
    end else if (side_f.n <= 6'd8) begin
      sol_next = shl[40] ? MAX40 : shl[SOL_W-1:0];
    end else begin
      sol_next = SOL_W'(shr);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sol <= sol_next;
    end
  end

endmodule

`default_nettype wire

// File: design/sf6_solubility_saturation.sv
`timescale 1ns / 1ps
`default_nettype none

// SF6 solubility and saturation for a stream of ocean grid cells.
// Input items arrive on s_axis: temperature, salinity and latitude in tdata,
// the ocean and mixed-layer flags in tuser. Each item gives one result item
// on m_axis: solubility, atmospheric level and saturation in tdata, the
// saturation-written flag in tuser.
// The two hemisphere levels are set through cfg_we / cfg_index / cfg_data
// (index 0 north, index 1 south); the user must do so only while no item is
// in flight; the block does not enforce it.
// The datapath is a 70-register pipeline. One item enters per cycle while
// the pipeline is not held; the depth is set by the 28-stage divider and
// logarithm unit and the 14-term exponent series, two stages per term.
// When the receiver holds off m_axis_tready with a result waiting, the whole
// pipeline holds; the input register still takes one more item if it is
// empty. Nothing is lost or repeated across a stall.
// Reset clears the valid bits and both level registers to zero.
module sf6_solubility_saturation
  import sf6ss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // temperature [14:0], salinity [28:15], latitude [44:29], zero pad
  input  logic [47:0]          s_axis_tdata,
  // is_ocean [0], in_mixed_layer [1]
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // solubility [39:0], atm_level [63:40], saturation [103:64]
  output logic [103:0]         m_axis_tdata,
  // saturation_written [0]
  output logic [0:0]           m_axis_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CONC_W-1:0]    cfg_data
);

  localparam int S_X    = 3;
  localparam int S_SALT = 8;
  localparam int S_RL   = S_X + RL_STAGES;
  localparam int S_LN   = S_RL + 1;
  localparam int S_P2   = S_LN + 1;
  localparam int S_W    = S_P2 + 1;
  localparam int S_SOL  = S_W + EXP_LAT;
  localparam int S_PROD = S_SOL + 1;
  localparam int LAST   = S_PROD + 1;

  // level registers
  logic [CONC_W-1:0] north_conc, south_conc;

  always_ff @(posedge clk) begin
    if (rst) begin
      north_conc <= '0;
      south_conc <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NORTH: north_conc <= cfg_data;
        CFG_SOUTH: south_conc <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [LAST:0] vld;
  logic          advance;
  logic          load;

  assign advance       = ~vld[LAST] | m_axis_tready;
  assign load          = advance | ~vld[0];
  assign s_axis_tready = load;
  assign m_axis_tvalid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load) begin
        vld[0] <= s_axis_tvalid;
      end
      if (advance) begin
        vld[LAST:1] <= vld[LAST-1:0];
      end
    end
  end

  // input register
  logic signed [TEMP_W-1:0] temp0;
  logic [SAL_W-1:0]         sal0;
  logic signed [LAT_W-1:0]  lat0;
  logic [1:0]               flg0;

  always_ff @(posedge clk) begin
    if (load) begin
      temp0 <= s_axis_tdata[14:0];
      sal0  <= s_axis_tdata[28:15];
      lat0  <= s_axis_tdata[44:29];
      flg0  <= s_axis_tuser;
    end
  end

  // x from temperature, stages 1 to 3
  logic [TEMP_W-1:0] tofs;
  logic [28:0]       a1, a2;
  logic [19:0]       v1;
  logic [40:0]       q_full;
  logic [14:0]       q2;
  logic [X_W-1:0]    xq3;

  assign tofs   = {~temp0[TEMP_W-1], temp0[TEMP_W-2:0]};
  assign q_full = v1 * RECIP25;

  always_ff @(posedge clk) begin
    if (advance) begin
      a1  <= tofs * X_STEP;
      v1  <= 20'(tofs) * X_REM_STEP + X_ROUND;
      a2  <= a1;
      q2  <= q_full[39:25];
      xq3 <= X_BASE + X_W'(a2) + X_W'(q2);
    end
  end

  // atmospheric level from latitude, stages 1 to 3
  logic        in_north, in_south;
  logic [12:0] lat_d;
  logic [36:0] pn1, ps1;
  logic        north1, south1, north2, south2;
  logic [37:0] lsum;
  logic [26:0] lsum2;
  logic [54:0] lblend;
  logic [CONC_W-1:0] lvl_next;

  assign in_north = lat0 > LAT_BOUND;
  assign in_south = lat0 < -LAT_BOUND;
  assign lat_d    = 13'(lat0 + LAT_BOUND);
  assign lsum     = 38'(pn1) + 38'(ps1) + 38'(LAT_HALF);
  assign lblend   = lsum2 * RECIP5;

  always_comb begin
    if (north2) begin
      lvl_next = north_conc;
    end else if (south2) begin
      lvl_next = south_conc;
    end else begin
      lvl_next = lblend[53:30];
    end
  end

  logic [CONC_W-1:0] lvl_d [S_X:LAST];

  always_ff @(posedge clk) begin
    if (advance) begin
      pn1    <= north_conc * lat_d;
      ps1    <= south_conc * 13'(LAT_SPAN - lat_d);
      north1 <= in_north;
      south1 <= in_south;
      lsum2  <= lsum[36:10];
      north2 <= north1;
      south2 <= south1;
      lvl_d[S_X] <= lvl_next;
      for (int i = S_X + 1; i <= LAST; i++) begin
        lvl_d[i] <= lvl_d[i-1];
      end
    end
  end

  // flags and salinity travel alongside
  logic [1:0]       flg_d [1:LAST];
  logic [SAL_W-1:0] sal_d [1:S_SALT-2];

  always_ff @(posedge clk) begin
    if (advance) begin
      flg_d[1] <= flg0;
      for (int i = 2; i <= LAST; i++) begin
        flg_d[i] <= flg_d[i-1];
      end
      sal_d[1] <= sal0;
      for (int i = 2; i <= S_SALT - 2; i++) begin
        sal_d[i] <= sal_d[i-1];
      end
    end
  end

  // salinity coefficient a3 + a4 x + a5 x^2 times salinity, stages 4 to 8
  logic [59:0]        x2_full;
  logic [53:0]        a4_full;
  logic [31:0]        x2_4;
  logic [25:0]        a4t4, a4t5;
  logic [52:0]        a5_full;
  logic [24:0]        a5t5;
  logic signed [31:0] c6;
  logic [31:0]        cmag;
  logic [45:0]        smag_full;
  logic [37:0]        smag7;
  logic               sneg7;
  logic signed [W_W-1:0] salt_d [S_SALT:S_P2];

  assign x2_full   = xq3 * xq3;
  assign a4_full   = A4_MAG_Q28 * xq3;
  assign a5_full   = A5_Q28 * x2_4;
  assign cmag      = c6[31] ? 32'(-c6) : 32'(c6);
  assign smag_full = cmag * sal_d[S_SALT-2];

  always_ff @(posedge clk) begin
    if (advance) begin
      x2_4  <= x2_full[59:28];
      a4t4  <= a4_full[53:28];
      a5t5  <= a5_full[52:28];
      a4t5  <= a4t4;
      c6    <= A3_Q28 - $signed({6'b0, a4t5}) + $signed({7'b0, a5t5});
      smag7 <= smag_full[45:8];
      sneg7 <= c6[31];
      salt_d[S_SALT] <= sneg7 ? -$signed({2'b00, smag7}) : $signed({2'b00, smag7});
      for (int i = S_SALT + 1; i <= S_P2; i++) begin
        salt_d[i] <= salt_d[i-1];
      end
    end
  end

  // reciprocal and log2 fraction of x
  logic [INV_W-1:0]  inv31;
  logic [FRAC_W-1:0] frac31;

  sf6ss_recip_log u_recip_log (
    .clk     (clk),
    .en      (advance),
    .xq      (xq3),
    .inv     (inv31),
    .ln_frac (frac31)
  );

  // exponent w, stages S_LN to S_W
  logic [56:0]           ln_full;
  logic [61:0]           p1_full, p2_full;
  logic [28:0]           lnx;
  logic [33:0]           p1, p1_d, p2;
  logic signed [W_W-1:0] w;

  assign ln_full = (Q28_ONE + 29'(frac31)) * LN2_Q28;
  assign p1_full = A1_Q28 * inv31;
  assign p2_full = A2_Q28 * lnx;

  always_ff @(posedge clk) begin
    if (advance) begin
      lnx  <= ln_full[56:28];
      p1   <= p1_full[61:28];
      p2   <= p2_full[61:28];
      p1_d <= p1;
      w    <= A0_Q28 + $signed({6'b0, p1_d}) + $signed({6'b0, p2}) + salt_d[S_P2];
    end
  end

  // solubility
  logic [SOL_W-1:0] sol;

  sf6ss_exp u_exp (
    .clk (clk),
    .en  (advance),
    .w   (w),
    .sol (sol)
  );

  // saturation product
  logic [63:0]      satp;
  logic [SOL_W-1:0] sol_p;
  logic [64:0]      sat_round;
  logic [48:0]      sat_sh;

  assign sat_round = 65'(satp) + 65'd32768;
  assign sat_sh    = sat_round[64:16];

  always_ff @(posedge clk) begin
    if (advance) begin
      satp  <= sol * lvl_d[S_SOL];
      sol_p <= sol;
    end
  end

  // output register
  logic [SOL_W-1:0]  out_sol, out_sat;
  logic [CONC_W-1:0] out_lvl;
  logic              out_wr;
  logic              ocean_p, mixed_p;

  assign ocean_p = flg_d[S_PROD][0];
  assign mixed_p = flg_d[S_PROD][1];

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sol <= ocean_p ? sol_p : '0;
      out_lvl <= lvl_d[S_PROD];
      if (ocean_p && mixed_p) begin
        out_sat <= (sat_sh > 49'(MAX40)) ? MAX40 : sat_sh[SOL_W-1:0];
      end else begin
        out_sat <= '0;
      end
      out_wr  <= ~ocean_p | mixed_p;
    end
  end

  assign m_axis_tdata = {out_sat, out_lvl, out_sol};
  assign m_axis_tuser = out_wr;

endmodule

`default_nettype wire
